/* design/mdfe_pkg.sv */
// Package for the MDIO management frame engine.
// Holds frame geometry, field codes and the transaction structs shared by all modules.
// Depends on nothing.
`timescale 1ns / 1ps

package mdfe_pkg;

    // Frame geometry.
    localparam int PREAMBLE_BITS = 32;
    localparam int HDR_BITS      = 14;
    localparam int DATA_BITS     = 16;
    localparam int POS_W         = 7;
    localparam int HDR_IDX_W     = 4;
    localparam int DATA_IDX_W    = 4;
    localparam int ADDR_W        = 5;

    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [HDR_BITS-1:0]   hdr_t;
    typedef logic [DATA_BITS-1:0]  data_t;
    typedef logic [ADDR_W-1:0]     addr_t;

    // Period numbers inside a frame.
    localparam pos_t PRE_END = pos_t'(PREAMBLE_BITS);
    localparam pos_t HDR_END = pos_t'(PREAMBLE_BITS + HDR_BITS);
    localparam pos_t WR_LAST = pos_t'(PREAMBLE_BITS + HDR_BITS + 2 + DATA_BITS - 1);
    localparam pos_t RD_LAST = pos_t'(PREAMBLE_BITS + HDR_BITS + 1 + DATA_BITS + 3 - 1);
    localparam pos_t RD_DATA_LAST = pos_t'(PREAMBLE_BITS + HDR_BITS + DATA_BITS);

    // Field codes of the clause-22 header.
    localparam logic [1:0] START_CODE = 2'b01;
    localparam logic [1:0] OP_WRITE   = 2'b01;
    localparam logic [1:0] OP_READ    = 2'b10;

    // Configuration register indexes and reset values.
    localparam logic [0:0] CFG_INTERNAL_PHY = 1'b0;
    localparam logic [0:0] CFG_EXTERNAL_PHY = 1'b1;
    localparam addr_t INTERNAL_PHY_RESET = addr_t'(1);
    localparam addr_t EXTERNAL_PHY_RESET = addr_t'(0);

    // One input transaction.
    typedef struct packed {
        logic  start_req;
        logic  is_write;
        addr_t phy_addr;
        addr_t reg_addr;
        data_t write_data;
        logic  mdio_in_internal;
        logic  mdio_in_external;
    } req_t;

    // One result transaction.
    typedef struct packed {
        logic  mdio_out;
        logic  mdio_drive;
        logic  busy;
        logic  done;
        data_t read_data;
    } res_t;

endpackage

/* design/mdfe_frame_core.sv */
// Frame state and per-period bit logic of the MDIO management frame engine.
// Holds the configuration registers and produces one result per accepted transaction.
// Depends on mdfe_pkg.
`timescale 1ns / 1ps

module mdfe_frame_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  mdfe_pkg::addr_t   cfg_wdata,
    input  logic              fire,
    input  mdfe_pkg::req_t    req,
    output mdfe_pkg::res_t    res
);
    import mdfe_pkg::*;

    addr_t internal_phy_reg;
    addr_t external_phy_reg;
    pos_t  position_reg;
    logic  active_reg;
    logic  is_write_reg;
    hdr_t  header_reg;
    data_t data_shift_reg;
    addr_t latched_phy_reg;
    data_t read_acc_reg;

    logic  start_now;
    pos_t  pos;
    logic  isw;
    hdr_t  hdr;
    data_t dsh;
    addr_t phy;
    pos_t  hdr_off;
    pos_t  tail_off;
    logic [HDR_IDX_W-1:0]  hdr_idx;
    logic [DATA_IDX_W-1:0] data_idx;
    logic  pin_bit;
    logic  sample;
    logic  last;

    pos_t  position_next;
    logic  active_next;
    data_t read_acc_next;

    // A request is taken only when no frame runs; the new frame starts in the same period.
    always_comb
    begin
        start_now = !active_reg && req.start_req;
        pos = start_now ? '0 : position_reg;
        isw = start_now ? req.is_write : is_write_reg;
        hdr = start_now ? {START_CODE, (req.is_write ? OP_WRITE : OP_READ),
                           req.phy_addr, req.reg_addr} : header_reg;
        dsh = start_now ? req.write_data : data_shift_reg;
        phy = start_now ? req.phy_addr : latched_phy_reg;
    end

    // Bit indexes into the header and the write data, MSB first.
    always_comb
    begin
        hdr_off  = pos - PRE_END;
        tail_off = pos - HDR_END;
        hdr_idx  = HDR_IDX_W'(HDR_BITS - 1) - hdr_off[HDR_IDX_W-1:0];
        data_idx = DATA_IDX_W'(DATA_BITS - 1) - (tail_off[DATA_IDX_W-1:0] - DATA_IDX_W'(2));
    end

    // The internal pin wins when both addresses match the latched PHY.
    always_comb
    begin
        if (phy == internal_phy_reg)
        begin
            pin_bit = req.mdio_in_internal;
        end
        else if (phy == external_phy_reg)
        begin
            pin_bit = req.mdio_in_external;
        end
        else
        begin
            pin_bit = 1'b0;
        end
    end

    // Output bit, drive enable and read sampling for this period.
    always_comb
    begin
        res.mdio_out   = 1'b0;
        res.mdio_drive = 1'b0;
        res.busy       = 1'b0;
        res.done       = 1'b0;
        sample         = 1'b0;
        last           = 1'b0;
        if (start_now || active_reg)
        begin
            res.busy = 1'b1;
            if (pos < PRE_END)
            begin
                res.mdio_drive = 1'b1;
                res.mdio_out   = 1'b1;
            end
            else if (pos < HDR_END)
            begin
                res.mdio_drive = 1'b1;
                res.mdio_out   = hdr[hdr_idx];
            end
            else if (isw)
            begin
                res.mdio_drive = 1'b1;
                if (tail_off == pos_t'(0))
                begin
                    res.mdio_out = 1'b1;
                end
                else if (tail_off == pos_t'(1))
                begin
                    res.mdio_out = 1'b0;
                end
                else
                begin
                    res.mdio_out = dsh[data_idx];
                end
            end
            else
            begin
                sample = (pos > HDR_END) && (pos <= RD_DATA_LAST);
            end
            last     = isw ? (pos >= WR_LAST) : (pos >= RD_LAST);
            res.done = last;
        end
        read_acc_next = sample ? {read_acc_reg[DATA_BITS-2:0], pin_bit} : read_acc_reg;
        res.read_data = read_acc_next;
    end

    // Next frame position and activity.
    always_comb
    begin
        if (start_now || active_reg)
        begin
            active_next   = !last;
            position_next = last ? '0 : pos + pos_t'(1);
        end
        else
        begin
            active_next   = 1'b0;
            position_next = '0;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            internal_phy_reg <= INTERNAL_PHY_RESET;
            external_phy_reg <= EXTERNAL_PHY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INTERNAL_PHY: internal_phy_reg <= cfg_wdata;
                CFG_EXTERNAL_PHY: external_phy_reg <= cfg_wdata;
                default:          internal_phy_reg <= internal_phy_reg;
            endcase
        end
    end

    // Frame state advances once per accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            active_reg      <= 1'b0;
            is_write_reg    <= 1'b0;
            header_reg      <= '0;
            data_shift_reg  <= '0;
            latched_phy_reg <= '0;
            read_acc_reg    <= '0;
        end
        else if (fire)
        begin
            position_reg    <= position_next;
            active_reg      <= active_next;
            is_write_reg    <= isw;
            header_reg      <= hdr;
            data_shift_reg  <= dsh;
            latched_phy_reg <= phy;
            read_acc_reg    <= read_acc_next;
        end
    end

    // An idle engine always sits at the start of a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> position_reg == '0)
        else $error("idle engine with nonzero frame position");

    // A running frame never passes its last period.
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> position_reg <= RD_LAST)
        else $error("frame position beyond the longest frame");

    // The final period of a frame leaves the engine idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.done |=> !active_reg)
        else $error("engine still active after the final period");

    // Without a transaction the frame does not move.
    assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(position_reg) && $stable(read_acc_reg))
        else $error("frame state changed without a transaction");

endmodule

/* design/mdfe_out_stage.sv */
// Result register of the MDIO management frame engine.
// Holds one result transaction until the consumer takes it; depends on mdfe_pkg.
`timescale 1ns / 1ps

module mdfe_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            fire,
    input  mdfe_pkg::res_t  res,
    output logic            out_valid,
    input  logic            out_ready,
    output mdfe_pkg::res_t  out_res
);
    import mdfe_pkg::*;

    logic out_valid_reg;
    logic out_valid_next;
    res_t res_reg;

    // A new transaction is taken when the register is empty or drains this cycle.
    assign in_ready  = !out_valid_reg || out_ready;
    assign fire      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res;
        end
    end

endmodule

/* design/mdio_management_frame_engine_unit.sv */
// Top level of the MDIO clause-22 management frame engine.
// Depends on mdfe_pkg, mdfe_frame_core and mdfe_out_stage.
`timescale 1ns / 1ps

// Each input transaction is one MDC bit period and yields exactly one result
// transaction in the registered output stage; a new transaction is accepted every cycle as long
// as the result register is empty or being drained, so throughput is one period
// per clock. A write frame lasts 64 periods and a read frame 66 periods (46
// driven header periods, one turnaround, 16 sampled data bits, 3 idle). A start
// request is honored only while no frame runs. The PHY address registers (index
// 0 internal, 1 external) should be written only while no frame is in progress.
module mdio_management_frame_engine_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [0:0]               cfg_index,
    input  logic [4:0]               cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     start_req,
    input  logic                     is_write,
    input  logic [4:0]               phy_addr,
    input  logic [4:0]               reg_addr,
    input  logic [15:0]              write_data,
    input  logic                     mdio_in_internal,
    input  logic                     mdio_in_external,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     mdio_out,
    output logic                     mdio_drive,
    output logic                     busy_res,
    output logic                     done_res,
    output logic [15:0]              read_data
);
    import mdfe_pkg::*;

    req_t req;
    res_t res;
    res_t out_res;
    logic fire;

    // Gather the input transaction.
    assign req.start_req        = start_req;
    assign req.is_write         = is_write;
    assign req.phy_addr         = phy_addr;
    assign req.reg_addr         = reg_addr;
    assign req.write_data       = write_data;
    assign req.mdio_in_internal = mdio_in_internal;
    assign req.mdio_in_external = mdio_in_external;

    mdfe_frame_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .req       (req),
        .res       (res)
    );

    mdfe_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .fire      (fire),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    // Spread the result transaction onto its ports.
    assign mdio_out   = out_res.mdio_out;
    assign mdio_drive = out_res.mdio_drive;
    assign busy_res   = out_res.busy;
    assign done_res   = out_res.done;
    assign read_data  = out_res.read_data;

endmodule
